/* hdl/dqd_pkg.sv */
// Shared types, constants and the transition table for the debounced quadrature decoder.
package dqd_pkg;

    localparam int POSITION_BITS = 32;

    localparam int TIME_BITS     = 32;
    localparam int DEBOUNCE_BITS = 16;
    localparam int SPD_BITS      = 4;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int ACC_BITS      = 5;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPD       = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DIRECTION = 2'd2;

    localparam logic [1:0] EVT_NONE = 2'd0;
    localparam logic [1:0] EVT_INC  = 2'd1;
    localparam logic [1:0] EVT_DEC  = 2'd2;

    typedef logic signed [1:0] step_t;

    typedef struct packed {
        logic [DEBOUNCE_BITS-1:0] debounce_ms;
        logic [SPD_BITS-1:0]      steps_per_detent;
        logic                     direction_reverse;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        debounce_ms:       16'd5,
        steps_per_detent:  4'd4,
        direction_reverse: 1'b0
    };

    // index = {previous state, current state}
    localparam step_t QUAD_TABLE [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

endpackage

/* hdl/dqd_debounce.sv */
// Per-channel debouncer: raw level tracking, change timestamp and stable level.
module dqd_debounce (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic [dqd_pkg::TIME_BITS-1:0]       now_ms,
    input  logic                                sample,
    input  logic [dqd_pkg::DEBOUNCE_BITS-1:0]   debounce_ms,
    output logic                                stable_next
);
    import dqd_pkg::*;

    logic                 raw_reg;
    logic                 stable_reg;
    logic [TIME_BITS-1:0] change_reg;
    logic [TIME_BITS-1:0] change_next;
    logic [TIME_BITS-1:0] elapsed;

    always_comb
    begin
        change_next = (sample != raw_reg) ? now_ms : change_reg;
        elapsed     = now_ms - change_next;
        if ((sample != stable_reg) &&
            (elapsed >= TIME_BITS'(debounce_ms)))
        begin
            stable_next = sample;
        end
        else
        begin
            stable_next = stable_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg    <= 1'b1;
            stable_reg <= 1'b1;
            change_reg <= '0;
        end
        else if (advance)
        begin
            raw_reg    <= sample;
            stable_reg <= stable_next;
            change_reg <= change_next;
        end
    end

endmodule

/* hdl/dqd_step.sv */
// Quadrature transition decode, step accumulator and detent counter.
module dqd_step (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic [1:0]                          quad,
    input  dqd_pkg::cfg_t                       cfg,
    output logic [1:0]                          detent_event,
    output logic [dqd_pkg::POSITION_BITS-1:0]   count_next
);
    import dqd_pkg::*;

    logic [1:0]                 prev_reg;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [ACC_BITS-1:0] acc_next;
    logic [POSITION_BITS-1:0]   count_reg;
    step_t                      step;
    logic signed [ACC_BITS:0]   sum;
    logic signed [ACC_BITS:0]   spd;

    always_comb
    begin
        step         = QUAD_TABLE[{prev_reg, quad}];
        spd          = $signed({{(ACC_BITS+1-SPD_BITS){1'b0}}, cfg.steps_per_detent});
        sum          = (ACC_BITS+1)'(acc_reg) +
                       (cfg.direction_reverse ? -(ACC_BITS+1)'(step)
                                              :  (ACC_BITS+1)'(step));
        acc_next     = acc_reg;
        count_next   = count_reg;
        detent_event = EVT_NONE;
        if (quad != prev_reg)
        begin
            if (step == 2'sd0)
            begin
                acc_next = '0;
            end
            else if (sum >= spd)
            begin
                acc_next     = '0;
                count_next   = count_reg + POSITION_BITS'(1);
                detent_event = EVT_INC;
            end
            else if (sum <= -spd)
            begin
                acc_next     = '0;
                count_next   = count_reg - POSITION_BITS'(1);
                detent_event = EVT_DEC;
            end
            else
            begin
                acc_next = sum[ACC_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            acc_reg   <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            prev_reg  <= quad;
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

endmodule

/* hdl/debounced_quadrature_decoder_top.sv */
// Top level of the debounced quadrature decoder: handshake, config and result register.
//
// Input channel: in_valid / in_stall carry one word of now_ms, raw_a, raw_b.
// Output channel: out_valid / out_stall carry one word of position,
// detent_event and quad_state for every input word, in order.
// A word is taken at an edge where valid is high and stall is low.
// Config: cfg_wr_en writes cfg_data into register cfg_addr (0 debounce_ms,
// 1 steps_per_detent, 2 direction_reverse); write only while idle.
// A word accepted into the input register is written to the result register once
// the output side is not stalled. Throughput: one word per cycle while unstalled,
// set by the single input register feeding the result register.
// A stalled result holds; the input register still fills behind it, and
// in_stall rises only when both registers are occupied and out_stall is high.
// Reset: config returns to 5 ms / 4 steps / normal direction, both pins read
// as high and stable, position count and accumulator clear, no words in flight.
module debounced_quadrature_decoder_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dqd_pkg::TIME_BITS-1:0]       now_ms,
    input  logic                                raw_a,
    input  logic                                raw_b,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [31:0]                  position,
    output logic [1:0]                          detent_event,
    output logic [1:0]                          quad_state,
    input  logic                                cfg_wr_en,
    input  logic [dqd_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [dqd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import dqd_pkg::*;

    cfg_t                     cfg_reg;
    logic                     in_valid_reg;
    logic [TIME_BITS-1:0]     now_reg;
    logic                     a_reg;
    logic                     b_reg;
    logic                     out_valid_reg;
    logic [31:0]              position_reg;
    logic [1:0]               event_reg;
    logic [1:0]               quad_reg;
    logic                     advance;
    logic                     in_take;
    logic                     stable_a;
    logic                     stable_b;
    logic [1:0]               quad;
    logic [1:0]               step_event;
    logic [POSITION_BITS-1:0] count_next;
    logic signed [63:0]       count_ext;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign quad     = {~stable_a, ~stable_b};
    assign count_ext = 64'($signed(count_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_DEBOUNCE:  cfg_reg.debounce_ms       <= cfg_data;
                CFG_SPD:       cfg_reg.steps_per_detent  <= cfg_data[SPD_BITS-1:0];
                CFG_DIRECTION: cfg_reg.direction_reverse <= cfg_data[0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg <= now_ms;
            a_reg   <= raw_a;
            b_reg   <= raw_b;
        end
        if (advance)
        begin
            position_reg <= count_ext[31:0];
            event_reg    <= step_event;
            quad_reg     <= quad;
        end
    end

    dqd_debounce u_deb_a (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .now_ms      (now_reg),
        .sample      (a_reg),
        .debounce_ms (cfg_reg.debounce_ms),
        .stable_next (stable_a)
    );

    dqd_debounce u_deb_b (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .now_ms      (now_reg),
        .sample      (b_reg),
        .debounce_ms (cfg_reg.debounce_ms),
        .stable_next (stable_b)
    );

    dqd_step u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .quad         (quad),
        .cfg          (cfg_reg),
        .detent_event (step_event),
        .count_next   (count_next)
    );

    assign out_valid    = out_valid_reg;
    assign position     = position_reg;
    assign detent_event = event_reg;
    assign quad_state   = quad_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipe");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed word lost before result register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        (out_valid && $stable(position) && $stable(detent_event) && $stable(quad_state)))
        else $error("stalled result word changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (detent_event != EVT_NONE)) |->
        (detent_event == EVT_INC || detent_event == EVT_DEC))
        else $error("illegal detent event code");
`endif

endmodule
